FILE: sv/dbdtp_pkg.sv
// ----------------------------------------------------------------------------
// dbdtp_pkg
// Shared types and constants of the double-buffered duty table player.
// ----------------------------------------------------------------------------
package dbdtp_pkg;

  // Entries per buffer; two buffers share one memory
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MEM_DEPTH   = 2 * TABLE_DEPTH;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int DUTY_W      = 16;
  localparam int ENTRY_W     = 3 * DUTY_W;

  // Command codes; code 3 is unused and ignored
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [7:0]        entry_index;
    logic [DUTY_W-1:0] phase_a_duty;
    logic [DUTY_W-1:0] phase_b_duty;
    logic [DUTY_W-1:0] phase_c_duty;
    logic [8:0]        table_size;
    logic              counting_down;
  } cmd_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] compare_a;
    logic [DUTY_W-1:0] compare_b;
    logic [DUTY_W-1:0] compare_c;
    logic              fire_detect;
  } res_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

FILE: sv/dbdtp_ram.sv
// ----------------------------------------------------------------------------
// dbdtp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dbdtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/double_buffered_duty_table_player_top.sv
// ----------------------------------------------------------------------------
// double_buffered_duty_table_player_top
// Three-phase PWM compare table player with two ping-pong buffers.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the duty memory to zero, one entry a
// cycle, over all 2 * TABLE_DEPTH entries (512 at the default depth);
// cmd_ready stays low during the sweep. After that a load or a commit
// gives no item. For a tick on the down count, the cycle it is accepted
// in updates the play pointer and buffer select and issues the read of
// the duty memory; then, in the read state, the registered read data is
// caught into the result register once that register is free. A tick on
// the up count and command 3 are dropped. The result register parts the
// two sides: a new item is accepted while a result still waits for
// res_ready. A second tick is accepted as well, but it then holds
// cmd_ready low until the earlier result has been taken.
// ----------------------------------------------------------------------------
module double_buffered_duty_table_player_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  dbdtp_pkg::cmd_item_t  cmd,
  output logic                  res_valid,
  input  logic                  res_ready,
  output dbdtp_pkg::res_item_t  res
);

  localparam int IDX_W   = dbdtp_pkg::IDX_W;
  localparam int LEN_W   = dbdtp_pkg::LEN_W;
  localparam int MEM_AW  = dbdtp_pkg::MEM_AW;
  localparam int ENTRY_W = dbdtp_pkg::ENTRY_W;
  localparam int DUTY_W  = dbdtp_pkg::DUTY_W;

  dbdtp_pkg::state_t state, state_next;

  // Control state
  logic [MEM_AW-1:0] clr_addr;
  logic [LEN_W-1:0]  buffer_length [2];
  logic              active_buffer;
  logic [LEN_W-1:0]  play_pointer;
  logic              switch_pending;
  logic              fire_hold;

  // Handshake and decode
  logic cmd_take;
  logic is_load;
  logic is_commit;
  logic is_tick;
  logic load_in_range;
  logic clr_last;

  // Tick arithmetic
  logic             wrap;
  logic             act_next;
  logic [LEN_W-1:0] ptr_base;
  logic [LEN_W-1:0] len_sel;
  logic             fire_calc;
  logic [LEN_W-1:0] commit_len;

  // Memory port
  logic               ram_we;
  logic [MEM_AW-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [MEM_AW-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               res_load;

  assign cmd_take      = cmd_valid && cmd_ready;
  assign is_load       = (cmd.command == dbdtp_pkg::CMD_LOAD);
  assign is_commit     = (cmd.command == dbdtp_pkg::CMD_COMMIT);
  assign is_tick       = (cmd.command == dbdtp_pkg::CMD_TICK) && cmd.counting_down;
  assign load_in_range = (32'(cmd.entry_index) < 32'(dbdtp_pkg::TABLE_DEPTH));
  assign clr_last      = (clr_addr == MEM_AW'(dbdtp_pkg::MEM_DEPTH - 1));

  // Saturate the committed length at the buffer depth
  assign commit_len = (32'(cmd.table_size) > 32'(dbdtp_pkg::TABLE_DEPTH)) ?
                      LEN_W'(dbdtp_pkg::TABLE_DEPTH) : LEN_W'(cmd.table_size);

  // Past the end of the active table: take the pending buffer if one is pending, restart at 0
  assign wrap      = (play_pointer >= buffer_length[active_buffer]);
  assign act_next  = (wrap && switch_pending) ? ~active_buffer : active_buffer;
  assign ptr_base  = wrap ? '0 : play_pointer;
  assign len_sel   = buffer_length[act_next];
  assign fire_calc = (ptr_base == '0) || (ptr_base == (len_sel >> 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dbdtp_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = dbdtp_pkg::ST_IDLE;
        end
      end
      dbdtp_pkg::ST_IDLE: begin
        if (cmd_take && is_tick) begin
          state_next = dbdtp_pkg::ST_READ;
        end
      end
      dbdtp_pkg::ST_READ: begin
        if (!res_valid || res_ready) begin
          state_next = dbdtp_pkg::ST_IDLE;
        end
      end
      default: state_next = dbdtp_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: memory port and handshake
  always_comb begin
    cmd_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = {act_next, IDX_W'(ptr_base)};
    res_load  = 1'b0;
    case (state)
      dbdtp_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      dbdtp_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        ram_we    = cmd_valid && is_load && load_in_range;
        ram_waddr = {~active_buffer, IDX_W'(cmd.entry_index)};
        ram_wdata = {cmd.phase_a_duty, cmd.phase_b_duty, cmd.phase_c_duty};
        ram_re    = cmd_valid && is_tick;
      end
      dbdtp_pkg::ST_READ: begin
        res_load = !res_valid || res_ready;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= dbdtp_pkg::ST_CLEAR;
      clr_addr         <= '0;
      buffer_length[0] <= '0;
      buffer_length[1] <= '0;
      active_buffer    <= 1'b0;
      play_pointer     <= '0;
      switch_pending   <= 1'b0;
      fire_hold        <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dbdtp_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + MEM_AW'(1);
      end
      if (cmd_take && is_commit) begin
        buffer_length[~active_buffer] <= commit_len;
        switch_pending                <= 1'b1;
      end
      if (cmd_take && is_tick) begin
        active_buffer <= act_next;
        if (wrap) begin
          switch_pending <= 1'b0;
        end
        play_pointer <= ptr_base + LEN_W'(1);
        fire_hold    <= fire_calc;
      end
      // Hold the result until taken; drop valid once it leaves
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res.compare_a   <= ram_rdata[3*DUTY_W-1:2*DUTY_W];
      res.compare_b   <= ram_rdata[2*DUTY_W-1:DUTY_W];
      res.compare_c   <= ram_rdata[DUTY_W-1:0];
      res.fire_detect <= fire_hold;
    end
  end

  // Both buffers in one memory, buffer select on the top address bit
  dbdtp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (dbdtp_pkg::MEM_DEPTH)
  ) u_duty_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
